// ===== design/gdad_pkg.sv =====
// Shared types, constants, calendar functions and the sequencer program for the date adder.
`default_nettype none

package gdad_pkg;

	localparam logic [13:0] MAX_YEAR   = 14'd9999;
	localparam logic [3:0]  LAST_MONTH = 4'd12;
	localparam logic [3:0]  FEBRUARY   = 4'd2;
	localparam logic [8:0]  YEAR_DAYS  = 9'd365;
	localparam logic [8:0]  LEAP_DAYS  = 9'd366;
	localparam logic [13:0] RECIP_100  = 14'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic [13:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [19:0] day_offset;
	} req_word_t;

	typedef struct packed {
		logic        date_valid;
		logic [8:0]  ordinal_day;
		logic [13:0] result_year;
		logic [3:0]  result_month;
		logic [4:0]  result_day;
		logic        year_overflow;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ORD,
		ST_YEAR,
		ST_MONTH,
		ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		COND_IN_VALID,
		COND_DATE_BAD,
		COND_ORD_DONE,
		COND_YEAR_FITS,
		COND_MONTH_FITS,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_ORD_ADD,
		OP_YEAR_SUB,
		OP_MONTH_SUB,
		OP_EMIT
	} op_t;

	typedef struct packed {
		cond_t cond;
		op_t   op;
		logic  do_hit;
		logic  do_miss;
		step_t tgt_hit;
		step_t tgt_miss;
	} cw_t;

	typedef struct packed {
		op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic date_bad;
		logic ord_done;
		logic year_fits;
		logic month_fits;
	} dp_stat_t;

	typedef struct packed {
		logic        bad;
		logic [8:0]  ord;
		logic [13:0] year;
		logic [3:0]  month;
		logic [20:0] rem;
	} dp_view_t;

	// The quotient by 100 comes from a reciprocal multiply, exact for every 14-bit year.
	function automatic logic is_leap(logic [13:0] y);
		logic [27:0] prod;
		logic [7:0]  q;
		logic [14:0] back;
		prod = 28'(y) * 28'(RECIP_100);
		q    = prod[RECIP_SHIFT +: 8];
		back = 15'(q) * 15'd100;
		if (back == 15'(y)) begin
			return q[1:0] == 2'd0;
		end
		return y[1:0] == 2'd0;
	endfunction

	function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
		logic [4:0] len;
		case (m)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
				len = 5'd31;
			end
			default: begin
				len = 5'd0;
			end
		endcase
		return len;
	endfunction

	function automatic cw_t ucode(step_t s);
		cw_t w;
		w = '{cond: COND_IN_VALID, op: OP_NONE, do_hit: 1'b0, do_miss: 1'b0,
			tgt_hit: ST_IDLE, tgt_miss: ST_IDLE};
		case (s)
			ST_IDLE: begin
				w = '{cond: COND_IN_VALID, op: OP_LOAD, do_hit: 1'b1, do_miss: 1'b0,
					tgt_hit: ST_CHECK, tgt_miss: ST_IDLE};
			end
			ST_CHECK: begin
				w = '{cond: COND_DATE_BAD, op: OP_INIT, do_hit: 1'b1, do_miss: 1'b1,
					tgt_hit: ST_EMIT, tgt_miss: ST_ORD};
			end
			ST_ORD: begin
				w = '{cond: COND_ORD_DONE, op: OP_ORD_ADD, do_hit: 1'b0, do_miss: 1'b1,
					tgt_hit: ST_YEAR, tgt_miss: ST_ORD};
			end
			ST_YEAR: begin
				w = '{cond: COND_YEAR_FITS, op: OP_YEAR_SUB, do_hit: 1'b0, do_miss: 1'b1,
					tgt_hit: ST_MONTH, tgt_miss: ST_YEAR};
			end
			ST_MONTH: begin
				w = '{cond: COND_MONTH_FITS, op: OP_MONTH_SUB, do_hit: 1'b0, do_miss: 1'b1,
					tgt_hit: ST_EMIT, tgt_miss: ST_MONTH};
			end
			ST_EMIT: begin
				w = '{cond: COND_OUT_BUSY, op: OP_EMIT, do_hit: 1'b0, do_miss: 1'b1,
					tgt_hit: ST_EMIT, tgt_miss: ST_IDLE};
			end
			default: begin
				w = '{cond: COND_IN_VALID, op: OP_NONE, do_hit: 1'b0, do_miss: 1'b0,
					tgt_hit: ST_IDLE, tgt_miss: ST_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== design/gdad_if.sv =====
// Valid/ready channel interfaces for the request and response words of the date adder.
`default_nettype none

interface gdad_req_if;
	logic                 valid;
	logic                 ready;
	gdad_pkg::req_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gdad_rsp_if;
	logic                 valid;
	logic                 ready;
	gdad_pkg::rsp_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/gdad_datapath.sv =====
// Calendar datapath: working registers, leap-year and month-length logic, loop conditions.
`default_nettype none

module gdad_datapath (
	input  wire logic                clk,
	input  wire gdad_pkg::dp_ctrl_t  ctrl,
	input  wire gdad_pkg::req_word_t word,
	output gdad_pkg::dp_stat_t       stat,
	output gdad_pkg::dp_view_t       view
);

	logic [13:0] y_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic [20:0] n_q;
	logic [8:0]  ord_q;
	logic [3:0]  mi_q;
	logic        bad_q;

	logic        leap_y;
	logic        leap_next;
	logic [8:0]  span;
	logic [4:0]  mlen_cur;
	logic [4:0]  mlen_idx;

	always_comb begin
		leap_y    = gdad_pkg::is_leap(y_q);
		leap_next = gdad_pkg::is_leap(y_q + 14'd1);
		if ((m_q <= gdad_pkg::FEBRUARY) ? leap_y : leap_next) begin
			span = gdad_pkg::LEAP_DAYS;
		end else begin
			span = gdad_pkg::YEAR_DAYS;
		end
		mlen_cur = gdad_pkg::month_len(m_q, leap_y);
		mlen_idx = gdad_pkg::month_len(mi_q, leap_y);

		stat.date_bad   = (y_q == 14'd0) || (y_q > gdad_pkg::MAX_YEAR) || (m_q == 4'd0) ||
			(m_q > gdad_pkg::LAST_MONTH) || (d_q == 5'd0) || (d_q > mlen_cur);
		stat.ord_done   = (mi_q == m_q);
		stat.year_fits  = (n_q <= {12'd0, span});
		stat.month_fits = (n_q <= {16'd0, mlen_cur});

		view.bad   = bad_q;
		view.ord   = ord_q;
		view.year  = y_q;
		view.month = m_q;
		view.rem   = n_q;
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			gdad_pkg::OP_LOAD: begin
				y_q <= word.start_year;
				m_q <= word.start_month;
				d_q <= word.start_day;
				n_q <= {1'b0, word.day_offset} + {16'd0, word.start_day};
			end
			gdad_pkg::OP_INIT: begin
				bad_q <= stat.date_bad;
				ord_q <= {4'd0, d_q};
				mi_q  <= 4'd1;
			end
			gdad_pkg::OP_ORD_ADD: begin
				ord_q <= ord_q + {4'd0, mlen_idx};
				mi_q  <= mi_q + 4'd1;
			end
			gdad_pkg::OP_YEAR_SUB: begin
				n_q <= n_q - {12'd0, span};
				y_q <= y_q + 14'd1;
			end
			gdad_pkg::OP_MONTH_SUB: begin
				n_q <= n_q - {16'd0, mlen_cur};
				if (m_q == gdad_pkg::LAST_MONTH) begin
					m_q <= 4'd1;
					y_q <= y_q + 14'd1;
				end else begin
					m_q <= m_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/gregorian_date_add_days_core.sv =====
// Top level of the Gregorian date adder: microcoded sequencer, datapath and result register.
//
//  channel | modport | word       | contents
//  --------+---------+------------+------------------------------------------------
//  req     | sink    | req_word_t | start year, month, day and forward day offset
//  rsp     | source  | rsp_word_t | validity, ordinal day, shifted date, overflow
//
// One word is processed at a time; req is ready only while the sequencer sits idle.
// A word passes from acceptance through a check step, one step per month before the
// start month, one per skipped year, one per skipped month and an emit step, which
// waits while the last result is still held on rsp, back to idle for the next word.
// An invalid date skips the walk and goes from the check step straight to emit.
// The year-skip loop of the sequencer removes one span per cycle.
// The result register lets the next word start while a result waits on rsp.
// Reset clears the step counter and the result valid flag.
`default_nettype none

module gregorian_date_add_days_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gdad_req_if.sink   req,
	gdad_rsp_if.source rsp
);

	gdad_pkg::step_t     pc_q;
	gdad_pkg::step_t     pc_d;
	gdad_pkg::cw_t       cw;
	gdad_pkg::dp_ctrl_t  dp_ctrl;
	gdad_pkg::dp_stat_t  dp_stat;
	gdad_pkg::dp_view_t  dp_view;
	gdad_pkg::rsp_word_t out_q;
	logic                out_valid_q;
	logic                hit;
	logic                fire;
	logic                overflow;

	gdad_datapath u_datapath (
		.clk  (clk),
		.ctrl (dp_ctrl),
		.word (req.data),
		.stat (dp_stat),
		.view (dp_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= gdad_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		cw = gdad_pkg::ucode(pc_q);
		case (cw.cond)
			gdad_pkg::COND_IN_VALID: begin
				hit = req.valid;
			end
			gdad_pkg::COND_DATE_BAD: begin
				hit = dp_stat.date_bad;
			end
			gdad_pkg::COND_ORD_DONE: begin
				hit = dp_stat.ord_done;
			end
			gdad_pkg::COND_YEAR_FITS: begin
				hit = dp_stat.year_fits;
			end
			gdad_pkg::COND_MONTH_FITS: begin
				hit = dp_stat.month_fits;
			end
			gdad_pkg::COND_OUT_BUSY: begin
				hit = out_valid_q && !rsp.ready;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		pc_d       = hit ? cw.tgt_hit : cw.tgt_miss;
		fire       = hit ? cw.do_hit : cw.do_miss;
		dp_ctrl.op = fire ? cw.op : gdad_pkg::OP_NONE;
	end

	assign req.ready = (pc_q == gdad_pkg::ST_IDLE);
	assign overflow  = (dp_view.year > gdad_pkg::MAX_YEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_ctrl.op == gdad_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.op == gdad_pkg::OP_EMIT) begin
			if (dp_view.bad) begin
				out_q <= '0;
			end else begin
				out_q.date_valid    <= 1'b1;
				out_q.ordinal_day   <= dp_view.ord;
				out_q.result_year   <= overflow ? 14'd0 : dp_view.year;
				out_q.result_month  <= dp_view.month;
				out_q.result_day    <= dp_view.rem[4:0];
				out_q.year_overflow <= overflow;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// A valid date always yields a real month and day.
	a_valid_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.date_valid |-> rsp.data.result_day != 5'd0 &&
		rsp.data.result_month != 4'd0 && rsp.data.result_month <= gdad_pkg::LAST_MONTH &&
		rsp.data.ordinal_day != 9'd0)
		else $error("valid date gave an empty result field");

	// An invalid date clears every field of the result.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.date_valid |-> rsp.data.ordinal_day == 9'd0 &&
		rsp.data.result_year == 14'd0 && rsp.data.result_month == 4'd0 &&
		rsp.data.result_day == 5'd0 && !rsp.data.year_overflow)
		else $error("invalid date gave a nonzero result");

	// Overflow only follows a valid date and hides the year.
	a_overflow_year: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.year_overflow |-> rsp.data.date_valid &&
		rsp.data.result_year == 14'd0)
		else $error("overflow result carries a year");

	// Once the year skips finish, the remainder fits within one span.
	a_month_rem: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == gdad_pkg::ST_MONTH |-> dp_view.rem <= {12'd0, gdad_pkg::LEAP_DAYS})
		else $error("remainder too large in month walk");

endmodule

`default_nettype wire

// ===== sim/tb_gregorian_date_add_days_core.sv =====
// Self-checking testbench for the Gregorian date adder: directed, random and stall tests.
`default_nettype none

module tb_gregorian_date_add_days_core;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int SHOW_LIMIT   = 10;
	localparam int OFFSET_MAX   = 1048575;
	localparam int RANDOM_WORDS = 165;

	logic clk = 1'b0;
	logic arst_n;

	gdad_req_if req_ch();
	gdad_rsp_if rsp_ch();

	gregorian_date_add_days_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gdad_pkg::rsp_word_t shifted_dates_due[$];

	int  cycle_count;
	int  mismatch_count;
	int  words_sent;
	int  results_checked;
	int  invalid_seen;
	int  overflow_seen;
	bit  req_idling;
	bit  rsp_idling;
	int  rsp_hold_request;
	bit  rsp_holding;

	always begin
		#4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit leap_year_of(int unsigned yr);
		return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(int unsigned mo, int unsigned yr);
		int unsigned len;
		case (mo)
			gdad_pkg::FEBRUARY: begin
				len = leap_year_of(yr) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				len = 30;
			end
			default: begin
				len = 31;
			end
		endcase
		return len;
	endfunction

	// A twelve-month span holds a leap day only if the February inside it is one.
	function automatic int unsigned twelve_month_days(int unsigned mo, int unsigned yr);
		return leap_year_of((mo <= gdad_pkg::FEBRUARY) ? yr : yr + 1) ? 366 : 365;
	endfunction

	function automatic gdad_pkg::rsp_word_t predict_shifted_date(gdad_pkg::req_word_t w);
		gdad_pkg::rsp_word_t r;
		int unsigned         yr;
		int unsigned         mo;
		int unsigned         dy;
		int unsigned         left;
		int unsigned         ord;
		int unsigned         i;
		r  = '0;
		yr = w.start_year;
		mo = w.start_month;
		dy = w.start_day;
		if (yr < 1 || yr > gdad_pkg::MAX_YEAR || mo < 1 || mo > gdad_pkg::LAST_MONTH ||
				dy < 1 || dy > days_in_month(mo, yr)) begin
			return r;
		end
		ord = dy;
		for (i = 1; i < mo; i++) begin
			ord += days_in_month(i, yr);
		end
		left = w.day_offset + dy;
		while (left > twelve_month_days(mo, yr)) begin
			left -= twelve_month_days(mo, yr);
			yr++;
		end
		while (left > days_in_month(mo, yr)) begin
			left -= days_in_month(mo, yr);
			mo++;
			if (mo == gdad_pkg::LAST_MONTH + 1) begin
				mo = 1;
				yr++;
			end
		end
		r.date_valid    = 1'b1;
		r.ordinal_day   = 9'(ord);
		r.result_year   = (yr > gdad_pkg::MAX_YEAR) ? 14'd0 : 14'(yr);
		r.result_month  = 4'(mo);
		r.result_day    = 5'(left);
		r.year_overflow = (yr > gdad_pkg::MAX_YEAR);
		return r;
	endfunction

	function automatic string show_result(gdad_pkg::rsp_word_t r);
		return $sformatf("valid %0d ord %0d date %0d-%0d-%0d overflow %0d", r.date_valid,
			r.ordinal_day, r.result_year, r.result_month, r.result_day, r.year_overflow);
	endfunction

	function automatic int unsigned idle_length();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(12, 48);
	endfunction

	function automatic int unsigned pick_offset();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return $urandom_range(0, 800);
		end else if (r < 88) begin
			return $urandom_range(0, 40000);
		end else if (r < 97) begin
			return $urandom_range(0, 400000);
		end else if (r < 99) begin
			return $urandom_range(0, OFFSET_MAX);
		end
		return OFFSET_MAX;
	endfunction

	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin : drive_ready
			int unsigned held;
			if (rsp_hold_request > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_holding = 1'b1;
				held = 0;
				while (held < rsp_hold_request) begin
					@(posedge clk);
					held++;
				end
				rsp_hold_request = 0;
				rsp_holding = 1'b0;
			end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (idle_length()) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		gdad_pkg::rsp_word_t want;
		gdad_pkg::rsp_word_t got;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (shifted_dates_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_LIMIT) begin
					$display("Unexpected result word: %s", show_result(got));
				end
			end else begin
				want = shifted_dates_due.pop_front();
				results_checked++;
				invalid_seen  += !want.date_valid;
				overflow_seen += want.year_overflow;
				if (got.date_valid !== want.date_valid || got.ordinal_day !== want.ordinal_day ||
						got.result_year !== want.result_year ||
						got.result_month !== want.result_month ||
						got.result_day !== want.result_day ||
						got.year_overflow !== want.year_overflow) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT) begin
						$display("Mismatch: expected %s", show_result(want));
						$display("          got      %s", show_result(got));
					end
				end
			end
		end
	end

	task automatic send_date(input int unsigned yr, input int unsigned mo,
			input int unsigned dy, input int unsigned off);
		gdad_pkg::req_word_t w;
		int unsigned         gap;
		w.start_year  = 14'(yr);
		w.start_month = 4'(mo);
		w.start_day   = 5'(dy);
		w.day_offset  = 20'(off);
		gap = 0;
		if (req_idling && $urandom_range(0, 2) == 0) begin
			gap = idle_length();
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		shifted_dates_due.push_back(predict_shifted_date(w));
		words_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (shifted_dates_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_calendar_corners();
		send_date(1, 1, 1, 0);
		send_date(9999, 12, 31, 0);
		send_date(9999, 12, 31, 1);
		send_date(1, 1, 1, OFFSET_MAX);
		send_date(9999, 1, 1, OFFSET_MAX);
		send_date(2000, 2, 29, 365);
		send_date(2000, 2, 29, 366);
		send_date(1900, 2, 28, 1);
		send_date(2100, 2, 28, 1);
		send_date(2024, 1, 31, 29);
		send_date(2023, 1, 31, 28);
		send_date(2024, 12, 31, 1);
		send_date(2023, 3, 1, 365);
		send_date(1, 12, 15, 31);
		send_date(8191, 6, 30, 524288);
	endtask

	task automatic test_invalid_dates();
		send_date(0, 1, 1, 5);
		send_date(10000, 1, 1, 5);
		send_date(16383, 15, 31, OFFSET_MAX);
		send_date(2023, 0, 10, 1);
		send_date(2023, 13, 1, 1);
		send_date(2023, 4, 31, 1);
		send_date(1900, 2, 29, 1);
		send_date(2024, 2, 30, 1);
		send_date(2023, 5, 0, 1);
	endtask

	task automatic test_random_dates();
		int unsigned yr;
		int unsigned mo;
		int unsigned dy;
		int unsigned r;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			req_idling = ((n / 25) % 3) != 0;
			rsp_idling = ((n / 20) % 4) != 1;
			if ($urandom_range(0, 6) == 0) begin
				send_date($urandom_range(0, 16383), $urandom_range(0, 15),
					$urandom_range(0, 31), $urandom_range(0, OFFSET_MAX));
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					yr = $urandom_range(9950, 9999);
				end else if (r == 1) begin
					yr = 100 * $urandom_range(1, 99);
				end else if (r == 2) begin
					yr = 4 * $urandom_range(1, 2499);
				end else begin
					yr = $urandom_range(1, 9999);
				end
				mo = $urandom_range(1, 12);
				if ($urandom_range(0, 3) == 0) begin
					dy = days_in_month(mo, yr);
				end else begin
					dy = $urandom_range(1, days_in_month(mo, yr));
				end
				send_date(yr, mo, dy, pick_offset());
			end
		end
	endtask

	task automatic test_result_stall();
		wait_drained();
		req_idling = 1'b0;
		rsp_hold_request = 300;
		wait (rsp_holding);
		@(posedge clk);
		for (int n = 0; n < 12; n++) begin
			send_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28),
				$urandom_range(0, 400));
		end
	endtask

	task automatic test_drain_pause();
		req_idling = 1'b1;
		rsp_idling = 1'b1;
		for (int n = 0; n < 8; n++) begin
			send_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28),
				pick_offset());
			if (n == 3) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		req_idling   = 1'b1;
		rsp_idling   = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_calendar_corners();
		test_invalid_dates();
		test_random_dates();
		test_result_stall();
		test_drain_pause();
		wait_drained();
		repeat (16) @(posedge clk);
		$display("Sent %0d words; checked %0d results, %0d of them invalid dates, %0d overflows.",
			words_sent, results_checked, invalid_seen, overflow_seen);
		$display("Covered calendar corners, random dates and offsets, a long result stall "
			, "and a full drain pause.");
		if (mismatch_count == 0 && shifted_dates_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
